// ===== sv/assert_macros.svh =====
// Assertion macros shared by the formatter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FPDF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FPDF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fpdf_pkg.sv =====
// Shared types and constants of the fixed-point decimal formatter.
package fpdf_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam int DIG_W      = 4;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = NUM_DIGITS * DIG_W;
    localparam int POS_W      = 5;

    localparam int MAX_DECIMALS  = 9;
    localparam int MAX_INT_WIDTH = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DECIMALS_IN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_CHAR    = 3'd3;

    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] PAD_RESET = 8'h20;

    // Format settings after clamping to their legal ranges.
    typedef struct packed {
        logic [3:0] dec_in;
        logic [4:0] int_w;
        logic [3:0] frac_w;
        logic [7:0] pad;
    } t_cfg;

endpackage

// ===== sv/fpdf_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add-three).
module fpdf_dabble import fpdf_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [VALUE_BITS-1:0] i_mag,
    output logic                  o_done,
    output logic [BCD_W-1:0]      o_bcd
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      n_adj;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_run;
    logic                  r_done;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i*DIG_W +: DIG_W] >= 4'd5) begin
                n_adj[i*DIG_W +: DIG_W] = r_bcd[i*DIG_W +: DIG_W] + 4'd3;
            end else begin
                n_adj[i*DIG_W +: DIG_W] = r_bcd[i*DIG_W +: DIG_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_bin <= i_mag;
                r_bcd <= '0;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_bcd <= {n_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ===== sv/fpdf_scale.sv =====
// Digit-serial decimal rescaler: shift, round, carry ripple and digit count.
`include "assert_macros.svh"
module fpdf_scale import fpdf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [BCD_W-1:0] i_bcd,
    input  t_cfg             i_cfg,
    output logic             o_done,
    output logic [BCD_W-1:0] o_bcd,
    output logic [POS_W-1:0] o_top
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UP   = 2'd1;
    localparam logic [1:0] S_DOWN = 2'd2;
    localparam logic [1:0] S_ROT  = 2'd3;

    logic [1:0]       r_state;
    logic [POS_W-1:0] r_cnt;
    logic [BCD_W-1:0] r_bcd;
    logic [POS_W-1:0] r_top;
    logic             r_carry;
    logic             r_done;

    logic [DIG_W:0]   w_sum;
    logic             w_ovf;
    logic [DIG_W-1:0] w_digit;

    // Low digit plus the pending carry.
    always_comb begin
        w_sum   = {1'b0, r_bcd[DIG_W-1:0]} + {{DIG_W{1'b0}}, r_carry};
        w_ovf   = (w_sum >= 5'd10);
        w_digit = w_ovf ? DIG_W'(w_sum - 5'd10) : w_sum[DIG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_load) begin
                        r_bcd   <= i_bcd;
                        r_carry <= 1'b0;
                        r_top   <= '0;
                        if (i_cfg.frac_w > i_cfg.dec_in) begin
                            r_cnt   <= {1'b0, i_cfg.frac_w - i_cfg.dec_in};
                            r_state <= S_UP;
                        end else if (i_cfg.dec_in > i_cfg.frac_w) begin
                            r_cnt   <= {1'b0, i_cfg.dec_in - i_cfg.frac_w};
                            r_state <= S_DOWN;
                        end else begin
                            r_cnt   <= '0;
                            r_state <= S_ROT;
                        end
                    end
                end
                S_UP: begin
                    // Multiply by ten: one digit left.
                    r_bcd <= {r_bcd[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 5'd1) begin
                        r_cnt   <= '0;
                        r_state <= S_ROT;
                    end
                end
                S_DOWN: begin
                    // Drop the low digit; carry rounds up into the next one.
                    r_carry <= (w_sum >= 5'd5);
                    r_bcd   <= {{DIG_W{1'b0}}, r_bcd[BCD_W-1:DIG_W]};
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == 5'd1) begin
                        r_cnt   <= '0;
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    // Ripple the rounding carry through all digits, note top nonzero.
                    r_bcd   <= {w_digit, r_bcd[BCD_W-1:DIG_W]};
                    r_carry <= w_ovf;
                    if (w_digit != '0) begin
                        r_top <= r_cnt;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == POS_W'(NUM_DIGITS - 1)) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;
    assign o_top  = r_top;

    `FPDF_ASSERT_IMP(a_rot_no_overflow, (r_state == S_ROT) && (r_cnt == POS_W'(NUM_DIGITS - 1)), !w_ovf, "carry left the top digit")
    `FPDF_ASSERT_NXT(a_done_idle, r_done, (r_state == S_IDLE) || i_load, "rescaler busy after done")

endmodule

// ===== sv/fpdf_emit.sv =====
// Character emitter: padding, sign, integer digits, point and fraction.
`include "assert_macros.svh"
module fpdf_emit import fpdf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [BCD_W-1:0] i_bcd,
    input  logic [POS_W-1:0] i_top,
    input  logic             i_neg,
    input  t_cfg             i_cfg,
    output logic             o_strobe,
    output logic [7:0]       o_char,
    output logic             o_last
);

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_SKIP = 3'd1;
    localparam logic [2:0] E_PAD  = 3'd2;
    localparam logic [2:0] E_SIGN = 3'd3;
    localparam logic [2:0] E_INT  = 3'd4;
    localparam logic [2:0] E_DOT  = 3'd5;
    localparam logic [2:0] E_FRAC = 3'd6;

    logic [2:0]       r_state;
    logic [BCD_W-1:0] r_bcd;
    logic [POS_W-1:0] r_skip;
    logic [POS_W-1:0] r_pad;
    logic [POS_W-1:0] r_int;
    logic [3:0]       r_frac;
    logic             r_neg;
    logic             r_strobe;
    logic [7:0]       r_char;
    logic             r_last;

    logic [POS_W-1:0] w_dp;
    logic [POS_W-1:0] w_intlen;
    logic [POS_W-1:0] w_skip;
    logic [POS_W-1:0] w_len;
    logic [POS_W-1:0] w_pad;
    logic [DIG_W-1:0] w_digit;

    // Integer digit count, leading zero digits to drop, padding count.
    always_comb begin
        w_dp     = {1'b0, i_cfg.frac_w};
        w_intlen = (i_top >= w_dp) ? (i_top - w_dp + 5'd1) : 5'd1;
        w_skip   = POS_W'(NUM_DIGITS) - w_dp - w_intlen;
        w_len    = w_intlen + {{(POS_W-1){1'b0}}, i_neg};
        w_pad    = (i_cfg.int_w > w_len) ? (i_cfg.int_w - w_len) : '0;
        w_digit  = r_bcd[BCD_W-1 -: DIG_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            case (r_state)
                E_IDLE: begin
                    if (i_load) begin
                        r_bcd   <= i_bcd;
                        r_skip  <= w_skip;
                        r_pad   <= w_pad;
                        r_int   <= w_intlen;
                        r_frac  <= i_cfg.frac_w;
                        r_neg   <= i_neg;
                        r_state <= E_SKIP;
                    end
                end
                E_SKIP: begin
                    if (r_skip != '0) begin
                        r_bcd  <= {r_bcd[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
                        r_skip <= r_skip - 1'b1;
                    end else begin
                        r_state <= E_PAD;
                    end
                end
                E_PAD: begin
                    if (r_pad != '0) begin
                        r_strobe <= 1'b1;
                        r_char   <= i_cfg.pad;
                        r_pad    <= r_pad - 1'b1;
                    end else begin
                        r_state <= E_SIGN;
                    end
                end
                E_SIGN: begin
                    if (r_neg) begin
                        r_strobe <= 1'b1;
                        r_char   <= CH_MINUS;
                    end
                    r_state <= E_INT;
                end
                E_INT: begin
                    r_strobe <= 1'b1;
                    r_char   <= CH_ZERO + {4'd0, w_digit};
                    r_bcd    <= {r_bcd[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    r_int    <= r_int - 1'b1;
                    if (r_int == 5'd1) begin
                        if (r_frac != '0) begin
                            r_state <= E_DOT;
                        end else begin
                            r_last  <= 1'b1;
                            r_state <= E_IDLE;
                        end
                    end
                end
                E_DOT: begin
                    r_strobe <= 1'b1;
                    r_char   <= CH_DOT;
                    r_state  <= E_FRAC;
                end
                E_FRAC: begin
                    r_strobe <= 1'b1;
                    r_char   <= CH_ZERO + {4'd0, w_digit};
                    r_bcd    <= {r_bcd[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    r_frac   <= r_frac - 1'b1;
                    if (r_frac == 4'd1) begin
                        r_last  <= 1'b1;
                        r_state <= E_IDLE;
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_char   = r_char;
    assign o_last   = r_last;

    `FPDF_ASSERT_IMP(a_digit_valid, (r_state == E_INT) || (r_state == E_FRAC), w_digit <= 4'd9, "non-decimal digit in output")

endmodule

// ===== sv/fixed_point_decimal_formatter.sv =====
// Top level of the fixed-point decimal formatter.
//
// Formats a signed fixed-point number (value / 10^decimals_in) as ASCII decimal
// text, one character per strobe on o_out_char, with o_last on the final
// character. A request is taken at a clock edge with start high and busy low;
// busy stays high until the last character has been shown. Characters come
// out as: pad_char until sign plus integer digits reach int_width, then '-'
// for a negative input (also when it rounds to zero), the integer digits
// without leading zeros, then '.' and frac_width fraction digits when
// frac_width is nonzero. The input is rescaled to frac_width decimals:
// missing decimals multiply by ten, surplus ones round with (v + 5) / 10 step
// by step. decimals_in and frac_width clamp at 9, int_width at 20.
// The receiver cannot stall: each character is valid for exactly one cycle.
// Busy covers the bit-serial binary to BCD converter, which takes the input
// one bit at a time; the rescaler, which makes one decimal step at a time
// and then a carry and digit-count pass over all 20 digit positions; and
// the emitter, which walks all 20 digit positions once (dropping leading
// zero digits or showing digits), shows the pad characters and passes
// through hand-over, sign and point. Configuration writes take effect at
// once and must be made only while busy is low.
`include "assert_macros.svh"
module fixed_point_decimal_formatter import fpdf_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                         o_strobe,
    output logic [7:0]                   o_out_char,
    output logic                         o_last
);

    // Configuration registers, stored as written.
    logic [3:0] r_dec_in;
    logic [4:0] r_int_w;
    logic [3:0] r_frac_w;
    logic [7:0] r_pad;

    logic       r_busy;
    logic       r_neg;

    t_cfg                  w_cfg;
    logic                  w_accept;
    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_mag;

    logic             w_dab_done;
    logic [BCD_W-1:0] w_dab_bcd;
    logic             w_scl_done;
    logic [BCD_W-1:0] w_scl_bcd;
    logic [POS_W-1:0] w_scl_top;

    // Clamp the settings to their legal ranges.
    always_comb begin
        w_cfg.dec_in = (r_dec_in > 4'(MAX_DECIMALS)) ? 4'(MAX_DECIMALS) : r_dec_in;
        w_cfg.frac_w = (r_frac_w > 4'(MAX_DECIMALS)) ? 4'(MAX_DECIMALS) : r_frac_w;
        w_cfg.int_w  = (r_int_w > 5'(MAX_INT_WIDTH)) ? 5'(MAX_INT_WIDTH) : r_int_w;
        w_cfg.pad    = r_pad;
    end

    // Take the magnitude; the most negative input maps to 2^(VALUE_BITS-1).
    assign w_accept = start && !r_busy;
    assign w_raw    = i_value;
    assign w_mag    = w_raw[VALUE_BITS-1]
                    ? (~w_raw + {{(VALUE_BITS-1){1'b0}}, 1'b1})
                    : w_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_in <= '0;
            r_int_w  <= '0;
            r_frac_w <= '0;
            r_pad    <= PAD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DECIMALS_IN: r_dec_in <= i_cfg_data[3:0];
                CFG_INT_WIDTH:   r_int_w  <= i_cfg_data[4:0];
                CFG_FRAC_WIDTH:  r_frac_w <= i_cfg_data[3:0];
                CFG_PAD_CHAR:    r_pad    <= i_cfg_data;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // Hold busy from the request until the final character has been shown.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (o_strobe && o_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= w_raw[VALUE_BITS-1];
        end
    end

    fpdf_dabble #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_mag   (w_mag),
        .o_done  (w_dab_done),
        .o_bcd   (w_dab_bcd)
    );

    fpdf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_dab_done),
        .i_bcd   (w_dab_bcd),
        .i_cfg   (w_cfg),
        .o_done  (w_scl_done),
        .o_bcd   (w_scl_bcd),
        .o_top   (w_scl_top)
    );

    fpdf_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_scl_done),
        .i_bcd    (w_scl_bcd),
        .i_top    (w_scl_top),
        .i_neg    (r_neg),
        .i_cfg    (w_cfg),
        .o_strobe (o_strobe),
        .o_char   (o_out_char),
        .o_last   (o_last)
    );

    assign busy = r_busy;

    `FPDF_ASSERT_IMP(a_strobe_in_request, o_strobe, busy, "character shown outside a request")
    `FPDF_ASSERT_NXT(a_accept_no_strobe, start && !busy, !o_strobe, "character right after a request")
    `FPDF_ASSERT_NXT(a_last_ends_request, o_strobe && o_last, !busy, "busy held after last character")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the fixed-point decimal formatter.
`timescale 1ns / 100ps

module testbench;
    import fpdf_pkg::*;

    localparam int VALUE_BITS = VALUE_BITS_DEF;
    // Generous bound: ~430 requests at worst-case gap, conversion and 30 chars each.
    localparam int TIMEOUT_NS = 3_000_000;
    // Cycles to watch for stray characters once nothing is expected.
    localparam int TAIL_CYCLES = 32;
    localparam int RANDOM_FORMATS = 4;
    localparam int ITEMS_PER_FORMAT = 34;
    localparam int MAX_GAP = 150;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam int CFG_IDX_LAST = (1 << CFG_IDX_W) - 1;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic signed [VALUE_BITS-1:0] i_value;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_idx;
    logic [CFG_DATA_W-1:0]        i_cfg_data;
    logic                         o_strobe;
    logic [7:0]                   o_out_char;
    logic                         o_last;

    // Shadow copy of the format registers, raw as written (clamping is applied on use).
    t_cfg fmt = '{dec_in: '0, int_w: '0, frac_w: '0, pad: PAD_RESET};

    t_text_char  pending_chars[$];
    int unsigned sender_idle_pct = 0;
    int unsigned errors = 0;
    int unsigned values_sent = 0;
    int unsigned formats_applied = 0;
    int unsigned chars_checked = 0;
    int unsigned minus_zero_seen = 0;

    fixed_point_decimal_formatter #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint unsigned pow10(input int unsigned n);
        longint unsigned p;
        p = 1;
        repeat (n) p = p * 10;
        return p;
    endfunction

    // Build the full text for one value under the current format and queue
    // its characters, flagging the final one.
    function automatic void format_value(input logic signed [VALUE_BITS-1:0] v);
        longint unsigned mag, divisor, ipart, fpart, t;
        int unsigned     dec, frac, width, ndig, used, k;
        logic            neg;
        logic [7:0]      text[$];
        neg = v[VALUE_BITS-1];
        // 64-bit magnitude: the most negative input needs no special wrap handling.
        mag = neg ? longint'(-longint'(v)) : longint'(v);
        dec = (fmt.dec_in > MAX_DECIMALS) ? MAX_DECIMALS : fmt.dec_in;
        frac = (fmt.frac_w > MAX_DECIMALS) ? MAX_DECIMALS : fmt.frac_w;
        width = (fmt.int_w > MAX_INT_WIDTH) ? MAX_INT_WIDTH : fmt.int_w;
        // Scale up by ten for missing decimals, round one step at a time for surplus.
        while (dec < frac) begin
            dec++;
            mag = mag * 10;
        end
        while (dec > frac) begin
            dec--;
            mag = (mag + 5) / 10;
        end
        if (neg && mag == 0) minus_zero_seen++;
        divisor = pow10(frac);
        ipart = mag / divisor;
        fpart = mag % divisor;
        ndig = 1;
        for (t = ipart; t >= 10; t = t / 10) ndig++;
        used = ndig + (neg ? 1 : 0);
        while (width > used) begin
            text.push_back(fmt.pad);
            used++;
        end
        // Sign stays even when the rounded magnitude is zero.
        if (neg) text.push_back(CH_MINUS);
        for (k = ndig; k > 0; k--) text.push_back(CH_ZERO + 8'((ipart / pow10(k - 1)) % 10));
        if (frac > 0) begin
            text.push_back(CH_DOT);
            for (k = frac; k > 0; k--)
                text.push_back(CH_ZERO + 8'((fpart / pow10(k - 1)) % 10));
        end
        foreach (text[i]) pending_chars.push_back('{ch: text[i], last: (i == text.size() - 1)});
    endfunction

    // Mix of full-range, small, tie-prone and extreme values.
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        logic signed [VALUE_BITS-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = int'($urandom_range(0, 2000)) - 1000;
            2: v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
            // Values ending in 5 exercise the chained round-half-up steps.
            3: v = $urandom_range(0, 99999) * 10 + 5;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = VALUE_MIN;
                    1: v = VALUE_MAX;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
        endcase
        if ($urandom_range(0, 1) == 1 && v != VALUE_MIN) v = -v;
        return v;
    endfunction

    // Issue one request: optional idle gap, then hold start until it is taken.
    task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
        int unsigned gap;
        gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, MAX_GAP) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        format_value(v);
        values_sent++;
    endtask

    // Drop start, drain every expected character and let the block settle.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_DECIMALS_IN: fmt.dec_in = data[3:0];
            CFG_INT_WIDTH:   fmt.int_w = data[4:0];
            CFG_FRAC_WIDTH:  fmt.frac_w = data[3:0];
            CFG_PAD_CHAR:    fmt.pad = data;
            default: ;  // unmapped index: the block ignores it
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_format(input logic [7:0] dec, input logic [7:0] iw,
                                input logic [7:0] fw, input logic [7:0] pad);
        wait_idle();
        write_reg(CFG_DECIMALS_IN, dec);
        write_reg(CFG_INT_WIDTH, iw);
        write_reg(CFG_FRAC_WIDTH, fw);
        write_reg(CFG_PAD_CHAR, pad);
        formats_applied++;
    endtask

    task automatic write_unmapped_regs();
        int idx;
        for (idx = CFG_PAD_CHAR + 1; idx <= CFG_IDX_LAST; idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
    endtask

    // Default format straight out of reset.
    task automatic test_reset_format();
        send_value(0);
        send_value(7);
        send_value(-7);
        send_value(VALUE_MAX);
        send_value(VALUE_MIN);
    endtask

    // Both rescaling directions with padding in front.
    task automatic test_scaling_and_padding();
        apply_format(2, 8, 4, "*");
        send_value(123456);
        send_value(-1);
        apply_format(4, 6, 1, "#");
        send_value(12345);
        send_value(-99999);
    endtask

    // Carries across rounding steps, and a negative value that rounds to zero.
    task automatic test_rounding_and_minus_zero();
        apply_format(3, 0, 1, " ");
        send_value(-40);
        send_value(-49);
        apply_format(2, 3, 0, "_");
        send_value(45);
        send_value(44);
        send_value(-44);
    endtask

    // Out-of-range settings clamp; writes to unmapped indexes change nothing.
    task automatic test_register_limits();
        apply_format(8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_value(VALUE_MAX);
        send_value(VALUE_MIN);
        send_value(0);
        wait_idle();
        write_unmapped_regs();
        send_value(-1);
        apply_format(0, MAX_INT_WIDTH, MAX_DECIMALS, 8'hFF);
        send_value(VALUE_MIN);
        send_value(VALUE_MAX);
        apply_format(MAX_DECIMALS, 0, 0, PAD_RESET);
        send_value(5);
        send_value(VALUE_MIN);
    endtask

    // Random formats and values at a given sender idle rate.
    task automatic test_random_formats(input int unsigned idle_pct);
        sender_idle_pct = idle_pct;
        repeat (RANDOM_FORMATS) begin
            apply_format($urandom, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 3) == 0) write_unmapped_regs();
            repeat (ITEMS_PER_FORMAT) send_value(pick_value());
        end
        sender_idle_pct = 0;
    endtask

    // Compare every strobed character with the oldest expectation.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_strobe) begin
            if (pending_chars.size() == 0) begin
                errors++;
                if (errors <= 20)
                    $display("%0t: unexpected char 8'h%02h last=%0b", $time, o_out_char, o_last);
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (o_out_char !== want.ch) begin
                    errors++;
                    if (errors <= 20)
                        $display("%0t: out_char mismatch: expected 8'h%02h got 8'h%02h",
                                 $time, want.ch, o_out_char);
                end
                if (o_last !== want.last) begin
                    errors++;
                    if (errors <= 20)
                        $display("%0t: last mismatch: expected %0b got %0b",
                                 $time, want.last, o_last);
                end
            end
        end
    end

    initial begin
        // Hold every input at a known value before the first edge.
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_value <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_format();
        test_scaling_and_padding();
        test_rounding_and_minus_zero();
        test_register_limits();
        test_random_formats(0);
        test_random_formats(61);
        test_random_formats(20);

        // Drain, then watch a while longer for stray characters.
        start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            errors++;
            $display("%0t: %0d expected chars never arrived", $time, pending_chars.size());
        end

        $display("Formatted %0d values under %0d register settings, %0d chars compared.",
                 values_sent, formats_applied, chars_checked);
        $display("Negative values rounding to zero: %0d; mismatches: %0d.",
                 minus_zero_seen, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timed out with %0d chars outstanding", $time, pending_chars.size());
        $display("FAIL");
        $finish;
    end

endmodule
